>>> sv/ovfm_pkg.sv
// -----------------------------------------------------------------------------
// ovfm_pkg
// Shared widths, register indexes and types of the overvoltage fault monitor.
// -----------------------------------------------------------------------------
package ovfm_pkg;

  localparam int SampleW = 12;
  localparam int CountW  = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [CountW-1:0]  count_t;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIP_THRESH         = 2'd0,
    REG_CLEAR_THRESH        = 2'd1,
    REG_TRIP_COUNT_LIMIT    = 2'd2,
    REG_RELEASE_COUNT_LIMIT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    sample_t trip_thresh;
    sample_t clear_thresh;
    count_t  trip_count_limit;
    count_t  release_count_limit;
  } cfg_t;

  typedef struct packed {
    logic fault_latched;
    logic standby_request;
    logic fault_released;
  } result_t;

  localparam sample_t TripThreshRst   = 12'd4095;
  localparam sample_t ClearThreshRst  = 12'd4000;
  localparam count_t  TripLimitRst    = 16'd0;
  localparam count_t  ReleaseLimitRst = 16'd1000;

endpackage

>>> sv/ovfm_in_if.sv
// -----------------------------------------------------------------------------
// ovfm_in_if
// Sample channel: valid/ready handshake carrying one voltage sample.
// -----------------------------------------------------------------------------
interface ovfm_in_if;
  import ovfm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t voltage_sample;

  modport source (output valid, output voltage_sample, input ready);
  modport sink   (input valid, input voltage_sample, output ready);
endinterface

>>> sv/ovfm_out_if.sv
// -----------------------------------------------------------------------------
// ovfm_out_if
// Result channel: valid/ready handshake carrying the fault status flags.
// -----------------------------------------------------------------------------
interface ovfm_out_if;
  import ovfm_pkg::*;

  logic valid;
  logic ready;
  logic fault_latched;
  logic standby_request;
  logic fault_released;

  modport source (output valid, output fault_latched, output standby_request,
                  output fault_released, input ready);
  modport sink   (input valid, input fault_latched, input standby_request,
                  input fault_released, output ready);
endinterface

>>> sv/ovfm_cfg.sv
// -----------------------------------------------------------------------------
// ovfm_cfg
// Configuration register file: write-only levels and count limits.
// -----------------------------------------------------------------------------
module ovfm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [ovfm_pkg::CfgIdxW-1:0]   idx,
  input  logic [ovfm_pkg::CfgDataW-1:0]  wdata,
  output ovfm_pkg::cfg_t                 cfg
);
  import ovfm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trip_thresh         <= TripThreshRst;
      cfg_r.clear_thresh        <= ClearThreshRst;
      cfg_r.trip_count_limit    <= TripLimitRst;
      cfg_r.release_count_limit <= ReleaseLimitRst;
    end else if (we) begin
      unique case (cfg_reg_t'(idx))
        REG_TRIP_THRESH:         cfg_r.trip_thresh         <= wdata[SampleW-1:0];
        REG_CLEAR_THRESH:        cfg_r.clear_thresh        <= wdata[SampleW-1:0];
        REG_TRIP_COUNT_LIMIT:    cfg_r.trip_count_limit    <= wdata[CountW-1:0];
        REG_RELEASE_COUNT_LIMIT: cfg_r.release_count_limit <= wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/ovfm_core.sv
// -----------------------------------------------------------------------------
// ovfm_core
// Trip/release counters and fault latch; one sample is evaluated per step.
// -----------------------------------------------------------------------------
module ovfm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ovfm_pkg::sample_t   sample,
  input  ovfm_pkg::cfg_t      cfg,
  output ovfm_pkg::result_t   res
);
  import ovfm_pkg::*;

  count_t trip_cnt_r, trip_cnt_nxt;
  count_t rel_cnt_r, rel_cnt_nxt;
  logic   fault_r, fault_nxt;

  logic [CountW:0] trip_inc;
  logic [CountW:0] trip_ceil;
  logic [CountW:0] trip_sat;
  count_t          rel_inc;
  logic            standby;
  logic            released;

  // Trip counter with hysteresis; trip comparison wins on overlapping levels
  always_comb begin
    trip_inc  = {1'b0, trip_cnt_r} + 1'b1;
    trip_ceil = {1'b0, cfg.trip_count_limit} + 1'b1;
    trip_sat  = (trip_inc > trip_ceil) ? trip_ceil : trip_inc;
    if (trip_sat[CountW]) begin
      trip_sat = {1'b0, CountMax};
    end
    priority if (sample > cfg.trip_thresh) begin
      trip_cnt_nxt = trip_sat[CountW-1:0];
    end else if (sample < cfg.clear_thresh) begin
      trip_cnt_nxt = '0;
    end else begin
      trip_cnt_nxt = trip_cnt_r;
    end
  end

  // Latch on trip, release after enough samples at zero trip count
  always_comb begin
    fault_nxt   = fault_r;
    rel_cnt_nxt = rel_cnt_r;
    standby     = 1'b0;
    released    = 1'b0;
    rel_inc     = (rel_cnt_r != CountMax) ? rel_cnt_r + 1'b1 : rel_cnt_r;
    if (!fault_r) begin
      if (trip_cnt_nxt > cfg.trip_count_limit) begin
        fault_nxt = 1'b1;
        standby   = 1'b1;
      end
    end else if (trip_cnt_nxt == '0) begin
      rel_cnt_nxt = rel_inc;
      if (rel_inc > cfg.release_count_limit) begin
        fault_nxt   = 1'b0;
        rel_cnt_nxt = '0;
        released    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_cnt_r <= '0;
      rel_cnt_r  <= '0;
      fault_r    <= 1'b0;
    end else if (step) begin
      trip_cnt_r <= trip_cnt_nxt;
      rel_cnt_r  <= rel_cnt_nxt;
      fault_r    <= fault_nxt;
    end
  end

  assign res.fault_latched   = fault_nxt;
  assign res.standby_request = standby;
  assign res.fault_released  = released;

endmodule

>>> sv/overvoltage_fault_monitor.sv
// -----------------------------------------------------------------------------
// overvoltage_fault_monitor
// Overvoltage protection with hysteresis, trip delay and recovery delay.
//
//   Channel   Direction  Handshake      Payload
//   in_ch     sink       valid/ready    voltage_sample[11:0]
//   out_ch    source     valid/ready    fault_latched, standby_request,
//                                       fault_released
//   cfg_*     sink       cfg_we only    cfg_index[1:0], cfg_wdata[15:0]
//
// One transaction per clock sustained while out_ch is not stalled; an accepted
// sample passes through the input register, then the result register.
// The trip/release counters and fault latch update in the result stage.
// A stall on out_ch holds both stages; in_ch.ready drops only when the
// input register is full and the result register cannot advance.
// Reset (rst_n low, synchronous) empties both stages, clears the counters
// and fault latch and loads the configuration reset values.
// -----------------------------------------------------------------------------
module overvoltage_fault_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  ovfm_in_if.sink                        in_ch,
  ovfm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ovfm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ovfm_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ovfm_pkg::*;

  cfg_t    cfg;
  result_t res;

  // Input stage
  logic    s1_valid_r;
  sample_t s1_sample_r;

  // Result stage
  logic    out_valid_r;
  result_t out_res_r;

  logic adv;    // result register can take a new value
  logic step;   // input-stage sample moves into the result stage
  logic in_acc;

  assign adv    = !out_valid_r || out_ch.ready;
  assign step   = adv && s1_valid_r;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc = in_ch.valid && in_ch.ready;

  ovfm_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  ovfm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  // Capture the sample; the slot refills in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.voltage_sample;
    end
  end

  // Result register: advance when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fault_latched   = out_res_r.fault_latched;
  assign out_ch.standby_request = out_res_r.standby_request;
  assign out_ch.fault_released  = out_res_r.fault_released;

  // A latching result always reports the fault as set
  a_standby_sets_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.standby_request |-> out_res_r.fault_latched)
    else $error("standby request without latched fault");

  // A releasing result always reports the fault as clear
  a_release_clears_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.fault_released |-> !out_res_r.fault_latched)
    else $error("fault released but still latched");

  // A stalled result must hold, and the core must not step under it
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_res_r))
    else $error("result changed while stalled");

  // A stepped input-stage sample always produces a result in the next cycle
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("stepped sample did not reach the result register");

endmodule
